FILE: hdl/lifegen_pkg.sv
package lifegen_pkg;

   // Default grid size
   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 32;

   // Request field widths
   localparam int FUNC_W      = 2;
   localparam int COL_W       = 6;
   localparam int ROW_FIELD_W = 5;

   // Stream payload widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = FUNC_W;
   localparam int RSP_TDATA_W = 8;

   // B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Operation codes carried in req_tuser
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_ADVANCE = 2'd3
   } func_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CELL_RD,
      ST_CELL_OP,
      ST_CLEAR,
      ST_ADV_LAST,
      ST_ADV_FIRST,
      ST_ADV_PRIME,
      ST_ADV_ROW,
      ST_RESP
   } state_type;

   // Grid memory read address select
   typedef enum logic [2:0] {
      RA_CELL,
      RA_LAST,
      RA_FIRST,
      RA_SECOND,
      RA_AHEAD
   } rdsel_type;

   // Controller to datapath
   typedef struct packed {
      logic      load_req;
      logic      rd_en;
      rdsel_type rd_sel;
      logic      cell_op;
      logic      clear;
      logic      load_up;
      logic      load_mid;
      logic      cnt_clr;
      logic      row_step;
      logic      load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_row;
      logic rsp_free;
   } status_type;

endpackage

FILE: hdl/life_grid_generation_engine_unit.sv
// Conway B3/S23 engine on a GRID_HEIGHT x GRID_WIDTH cell grid held in a one-read,
// one-write row memory. Each request beat writes a cell, reads a cell, clears the
// grid or advances one generation, and returns exactly one response beat. Items are
// handled one at a time: a new request is taken only once the response beat of the
// last one is loaded. During an advance the grid memory gives up one row per cycle,
// once three reads have primed the three-row window.
// Reset and clear empty the grid at once through per-row valid bits; no clearing pass
// is run. With csr_wr_data set, opposite edges are joined as a torus; write it only
// while the block is idle.
module life_grid_generation_engine_unit #(
   parameter int GRID_WIDTH  = lifegen_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = lifegen_pkg::GRID_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [5:0] cell_col, [10:6] cell_row, [11] write_alive, rest zero
   input  logic [lifegen_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] func
   input  logic [lifegen_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] read_alive, [1] op_done, rest zero
   output logic [lifegen_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // wrap_edges register
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data
);
   import lifegen_pkg::*;

   cmd_type    cmd;
   status_type status;

   lifegen_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   lifegen_dpath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: hdl/lifegen_ctrl.sv
module lifegen_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lifegen_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  lifegen_pkg::status_type               status,
   output lifegen_pkg::cmd_type                  cmd
);
   import lifegen_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RA_CELL;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_req = 1'b1;
               unique case (func_type'(req_tuser))
                  FUNC_WRITE, FUNC_READ: state_in = ST_CELL_RD;
                  FUNC_CLEAR:            state_in = ST_CLEAR;
                  FUNC_ADVANCE:          state_in = ST_ADV_LAST;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_CELL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_CELL;
            state_in   = ST_CELL_OP;
         end
         ST_CELL_OP: begin
            cmd.cell_op = 1'b1;
            state_in    = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_RESP;
         end
         // prime: bottom row, then top row, then second row
         ST_ADV_LAST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_LAST;
            state_in   = ST_ADV_FIRST;
         end
         ST_ADV_FIRST: begin
            cmd.load_up = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RA_FIRST;
            state_in    = ST_ADV_PRIME;
         end
         ST_ADV_PRIME: begin
            cmd.load_mid = 1'b1;
            cmd.cnt_clr  = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RA_SECOND;
            state_in     = ST_ADV_ROW;
         end
         // one row written per cycle
         ST_ADV_ROW: begin
            cmd.row_step = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RA_AHEAD;
            if (status.last_row) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/lifegen_dpath.sv
module lifegen_dpath #(
   parameter int GRID_WIDTH  = lifegen_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = lifegen_pkg::GRID_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [lifegen_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [lifegen_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data,
   input  lifegen_pkg::cmd_type                  cmd,
   output lifegen_pkg::status_type               status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lifegen_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import lifegen_pkg::*;

   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int CW    = $clog2(GRID_WIDTH);
   localparam int AW    = (ROW_W > ROW_FIELD_W) ? ROW_W : ROW_FIELD_W;

   // Latched request
   func_type               func_ff;
   logic [COL_W-1:0]       col_ff;
   logic [ROW_FIELD_W-1:0] row_ff;
   logic                   alive_ff;

   logic                   wrap_ff;

   // Grid storage
   logic [GRID_WIDTH-1:0]  grid_mem [GRID_HEIGHT];
   logic [GRID_HEIGHT-1:0] valid_ff;
   logic [GRID_WIDTH-1:0]  rd_data_ff;
   logic                   rd_valid_ff;

   // Generation window
   logic [GRID_WIDTH-1:0]  up_ff;
   logic [GRID_WIDTH-1:0]  mid_ff;
   logic [GRID_WIDTH-1:0]  first_ff;
   logic [ROW_W-1:0]       cnt_ff;

   logic                   rd_bit_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_read_ff;

   logic [AW-1:0]          row_ext;
   logic                   in_grid;
   logic [ROW_W-1:0]       cell_addr;
   logic [CW-1:0]          cell_bit;
   logic [GRID_WIDTH-1:0]  rd_row;
   logic [GRID_WIDTH-1:0]  cell_wd;
   logic [ROW_W:0]         ahead;
   logic                   ahead_ok;
   logic                   last_row;
   logic [GRID_WIDTH-1:0]  dn_row;
   logic [GRID_WIDTH-1:0]  new_row;
   logic                   mem_re;
   logic [ROW_W-1:0]       mem_ra;
   logic                   mem_we;
   logic [ROW_W-1:0]       mem_wa;
   logic [GRID_WIDTH-1:0]  mem_wd;

   // Cell address decode
   assign row_ext   = AW'(row_ff);
   assign in_grid   = ({1'b0, row_ext} < (AW + 1)'(GRID_HEIGHT))
                    && ({1'b0, col_ff} < (COL_W + 1)'(GRID_WIDTH));
   assign cell_addr = row_ext[ROW_W-1:0];
   assign cell_bit  = col_ff[CW-1:0];

   // Rows never written since reset or clear read as dead
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      cell_wd           = rd_row;
      cell_wd[cell_bit] = alive_ff;
   end

   // Row counter and look-ahead read
   assign ahead    = {1'b0, cnt_ff} + (ROW_W + 1)'(2);
   assign ahead_ok = ahead < (ROW_W + 1)'(GRID_HEIGHT);
   assign last_row = cnt_ff == ROW_W'(GRID_HEIGHT - 1);
   assign dn_row   = last_row ? (wrap_ff ? first_ff : '0) : rd_row;

   // B3/S23 over a whole row
   always_comb begin
      logic [GRID_WIDTH+1:0] up_x;
      logic [GRID_WIDTH+1:0] mid_x;
      logic [GRID_WIDTH+1:0] dn_x;
      logic [3:0]            nbr_cnt;
      up_x  = {wrap_ff & up_ff[0], up_ff, wrap_ff & up_ff[GRID_WIDTH-1]};
      mid_x = {wrap_ff & mid_ff[0], mid_ff, wrap_ff & mid_ff[GRID_WIDTH-1]};
      dn_x  = {wrap_ff & dn_row[0], dn_row, wrap_ff & dn_row[GRID_WIDTH-1]};
      new_row = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         nbr_cnt = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
                 + 4'(mid_x[c]) + 4'(mid_x[c+2])
                 + 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
         new_row[c] = (nbr_cnt == BIRTH_COUNT)
                    || (mid_ff[c] && (nbr_cnt == SURVIVE_COUNT));
      end
   end

   // Memory read port
   always_comb begin
      unique case (cmd.rd_sel)
         RA_CELL:   mem_ra = cell_addr;
         RA_LAST:   mem_ra = ROW_W'(GRID_HEIGHT - 1);
         RA_FIRST:  mem_ra = '0;
         RA_SECOND: mem_ra = ROW_W'(1);
         RA_AHEAD:  mem_ra = ahead[ROW_W-1:0];
         default:   mem_ra = '0;
      endcase
      mem_re = cmd.rd_en && ((cmd.rd_sel != RA_AHEAD) || ahead_ok);
   end

   // Memory write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = cnt_ff;
      mem_wd = new_row;
      if (cmd.row_step) begin
         mem_we = 1'b1;
      end else if (cmd.cell_op && (func_ff == FUNC_WRITE) && in_grid) begin
         mem_we = 1'b1;
         mem_wa = cell_addr;
         mem_wd = cell_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= grid_mem[mem_ra];
      end
   end

   // Row valid bits
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_valid_ff <= valid_ff[mem_ra];
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= func_type'(req_tuser);
         col_ff   <= req_tdata[COL_W-1:0];
         row_ff   <= req_tdata[COL_W +: ROW_FIELD_W];
         alive_ff <= req_tdata[COL_W + ROW_FIELD_W];
      end
   end

   // Torus mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
      end else if (csr_wr_en) begin
         wrap_ff <= csr_wr_data;
      end
   end

   // Sliding three-row window
   always_ff @(posedge clock) begin
      if (cmd.load_up) begin
         up_ff <= wrap_ff ? rd_row : '0;
      end else if (cmd.row_step) begin
         up_ff <= mid_ff;
      end
      if (cmd.load_mid) begin
         mid_ff   <= rd_row;
         first_ff <= rd_row;
      end else if (cmd.row_step) begin
         mid_ff <= dn_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.row_step) begin
         cnt_ff <= cnt_ff + ROW_W'(1);
      end
   end

   // Read result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rd_bit_ff <= 1'b0;
      end else if (cmd.cell_op && (func_ff == FUNC_READ)) begin
         rd_bit_ff <= in_grid & rd_row[cell_bit];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_ff <= rd_bit_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {(RSP_TDATA_W - 2)'(0), 1'b1, rsp_read_ff};
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign status.last_row = last_row;

   // Look-ahead read never hits the row being written
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_wa != mem_ra))
      else $error("grid read and write at the same row");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (valid_ff == '0))
      else $error("grid not empty after clear");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending response beat overwritten");

endmodule
